/* src/pipc_pkg.sv */
// Shared types and constants for the periodic image pair cutoff block.
`default_nettype none

package pipc_pkg;

    localparam int POS_W      = 32;              // signed Q15.16 position
    localparam int REG_W      = 31;              // unsigned Q15.16 register
    localparam int DIFF_W     = POS_W + 1;       // first - second
    localparam int SHIFT_W    = DIFF_W + 1;      // difference with one box shift
    localparam int SQ_W       = 2 * REG_W;       // square of an in-range magnitude
    localparam int SUM2_W     = SQ_W + 1;        // x^2 + y^2
    localparam int SUM3_W     = SQ_W + 2;        // x^2 + y^2 + z^2
    localparam int NUM_SHIFTS = 3;               // shift -1, 0, +1 per axis
    localparam int NUM_PAIRS  = NUM_SHIFTS * NUM_SHIFTS;
    localparam int NUM_IMAGES = NUM_PAIRS * NUM_SHIFTS;
    localparam int CODE_W     = 5;
    localparam logic [CODE_W-1:0] MAX_CODE = CODE_W'(NUM_IMAGES - 1);
    localparam int AXIS_LAT   = 4;               // register stages inside pipc_axis
    localparam int CFG_IDX_W  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_BOX_X  = 2'd0,
        CFG_BOX_Y  = 2'd1,
        CFG_BOX_Z  = 2'd2,
        CFG_CUTOFF = 2'd3
    } t_cfg_idx;

    // Per-axis squared distances for the three shifts, plus out-of-range flags.
    typedef struct packed {
        logic [NUM_SHIFTS-1:0][SQ_W-1:0] sq;
        logic [NUM_SHIFTS-1:0]           big;
    } t_axis_res;

endpackage

`default_nettype wire

/* src/pipc_axis.sv */
// One axis: difference, three box shifts, magnitude and square, four stages.
`default_nettype none

module pipc_axis (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_valid,
    input  wire logic signed [pipc_pkg::POS_W-1:0] i_first,
    input  wire logic signed [pipc_pkg::POS_W-1:0] i_second,
    input  wire logic        [pipc_pkg::REG_W-1:0] i_len,
    output      logic                              o_valid,
    output      pipc_pkg::t_axis_res               o_res
);
    import pipc_pkg::*;

    logic                     r_v1, r_v2, r_v3, r_v4;
    logic signed [DIFF_W-1:0] r_diff;
    logic signed [SHIFT_W-1:0] r_shift [NUM_SHIFTS];
    logic        [REG_W-1:0]  r_mag   [NUM_SHIFTS];
    logic        [NUM_SHIFTS-1:0] r_big3;
    t_axis_res                r_res;

    logic signed [SHIFT_W-1:0] n_diff_ext;
    logic signed [SHIFT_W-1:0] n_len_ext;
    logic        [SHIFT_W-1:0] n_abs [NUM_SHIFTS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    assign n_diff_ext = SHIFT_W'(r_diff);
    assign n_len_ext  = $signed({{(SHIFT_W-REG_W){1'b0}}, i_len});

    always_comb begin
        for (int s = 0; s < NUM_SHIFTS; s++) begin
            n_abs[s] = r_shift[s][SHIFT_W-1] ? SHIFT_W'(-r_shift[s]) : r_shift[s];
        end
    end

    always_ff @(posedge i_clk) begin
        r_diff <= DIFF_W'(i_first) - DIFF_W'(i_second);
        // shift index 0 is image -1 (adds a box length), 2 is image +1
        r_shift[0] <= n_diff_ext + n_len_ext;
        r_shift[1] <= n_diff_ext;
        r_shift[2] <= n_diff_ext - n_len_ext;
        for (int s = 0; s < NUM_SHIFTS; s++) begin
            r_mag[s]  <= n_abs[s][REG_W-1:0];
            r_big3[s] <= |n_abs[s][SHIFT_W-1:REG_W];
            r_res.sq[s] <= SQ_W'(r_mag[s]) * SQ_W'(r_mag[s]);
        end
        r_res.big <= r_big3;
    end

    assign o_valid = r_v4;
    assign o_res   = r_res;

`ifndef NO_ASSERTIONS
    a_valid_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, AXIS_LAT))
        else $error("axis valid without an item four cycles back");
    a_center_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_len == '0) && $stable(i_len) && $past(r_v1) |->
            r_shift[0] == r_shift[2])
        else $error("zero box length must give equal shifted differences");
    a_big_means_wide: assert property (@(posedge i_clk)
        r_v4 && r_res.big[1] |-> $past(r_big3[1]))
        else $error("center out-of-range flag lost between stages");
`endif

endmodule

`default_nettype wire

/* src/periodic_image_pair_cutoff.sv */
// Periodic image pair cutoff: top level, 27-image neighbor test of one atom pair.
// o_done follows an accepted item (start high, busy low) through every stage to stage 8.
// Throughput: one item per cycle; busy is held low and the pipeline never stalls.
// Squared cutoff is a register recomputed from the cutoff register, so it trails each write.
// Synchronous active-low reset clears the pipeline valid bits and loads the
// register reset values (unit box, zero cutoff).
`default_nettype none

module periodic_image_pair_cutoff (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire logic                                  start,
    output      logic                                  busy,
    input  wire logic                                  i_cfg_we,
    input  wire pipc_pkg::t_cfg_idx                    i_cfg_idx,
    input  wire logic        [pipc_pkg::REG_W-1:0]     i_cfg_data,
    input  wire logic signed [pipc_pkg::POS_W-1:0]     i_first_x,
    input  wire logic signed [pipc_pkg::POS_W-1:0]     i_first_y,
    input  wire logic signed [pipc_pkg::POS_W-1:0]     i_first_z,
    input  wire logic signed [pipc_pkg::POS_W-1:0]     i_second_x,
    input  wire logic signed [pipc_pkg::POS_W-1:0]     i_second_y,
    input  wire logic signed [pipc_pkg::POS_W-1:0]     i_second_z,
    input  wire logic                                  i_excluded,
    output      logic                                  o_done,
    output      logic                                  o_is_neighbor,
    output      logic        [pipc_pkg::CODE_W-1:0]    o_image_forward,
    output      logic        [pipc_pkg::CODE_W-1:0]    o_image_reverse
);
    import pipc_pkg::*;

    // configuration
    logic [REG_W-1:0] r_box_x, r_box_y, r_box_z, r_cutoff;
    logic [SQ_W-1:0]  r_rc2;

    logic      accept;
    logic      ax_valid;
    t_axis_res res_x, res_y, res_z;

    logic r_excl_d [AXIS_LAT];

    // stage 5: x+y sums, z delayed
    logic                  r_v5, r_e5;
    logic [SUM2_W-1:0]     r_sxy [NUM_PAIRS];
    logic [NUM_PAIRS-1:0]  r_bxy;
    t_axis_res             r_z5;
    // stage 6: full sums
    logic                  r_v6, r_e6;
    logic [SUM3_W-1:0]     r_s3 [NUM_IMAGES];
    logic [NUM_IMAGES-1:0] r_b3;
    // stage 7: compare
    logic                  r_v7, r_e7;
    logic [NUM_IMAGES-1:0] r_match;
    // stage 8: output
    logic                  r_done, r_nb;
    logic [CODE_W-1:0]     r_fwd, r_rev;

    logic              n_found;
    logic [CODE_W-1:0] n_code;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_x  <= REG_W'(65536);
            r_box_y  <= REG_W'(65536);
            r_box_z  <= REG_W'(65536);
            r_cutoff <= '0;
            r_rc2    <= '0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_BOX_X:  r_box_x  <= i_cfg_data;
                    CFG_BOX_Y:  r_box_y  <= i_cfg_data;
                    CFG_BOX_Z:  r_box_z  <= i_cfg_data;
                    CFG_CUTOFF: r_cutoff <= i_cfg_data;
                    default:    r_cutoff <= r_cutoff;
                endcase
            end
            r_rc2 <= SQ_W'(r_cutoff) * SQ_W'(r_cutoff);
        end
    end

    pipc_axis u_axis_x (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_first  (i_first_x),
        .i_second (i_second_x),
        .i_len    (r_box_x),
        .o_valid  (ax_valid),
        .o_res    (res_x)
    );

    pipc_axis u_axis_y (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_first  (i_first_y),
        .i_second (i_second_y),
        .i_len    (r_box_y),
        .o_valid  (),
        .o_res    (res_y)
    );

    pipc_axis u_axis_z (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (accept),
        .i_first  (i_first_z),
        .i_second (i_second_z),
        .i_len    (r_box_z),
        .o_valid  (),
        .o_res    (res_z)
    );

    always_ff @(posedge i_clk) begin
        r_excl_d[0] <= i_excluded;
        for (int k = 1; k < AXIS_LAT; k++) begin
            r_excl_d[k] <= r_excl_d[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v5   <= 1'b0;
            r_v6   <= 1'b0;
            r_v7   <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_v5   <= ax_valid;
            r_v6   <= r_v5;
            r_v7   <= r_v6;
            r_done <= r_v7;
        end
    end

    // image code t = 9*ix + 3*iy + iz, ix/iy/iz = shift index per axis
    for (genvar ix = 0; ix < NUM_SHIFTS; ix++) begin : g_x
        for (genvar iy = 0; iy < NUM_SHIFTS; iy++) begin : g_y
            localparam int P = ix * NUM_SHIFTS + iy;
            always_ff @(posedge i_clk) begin
                r_sxy[P] <= SUM2_W'(res_x.sq[ix]) + SUM2_W'(res_y.sq[iy]);
                r_bxy[P] <= res_x.big[ix] | res_y.big[iy];
            end
            for (genvar iz = 0; iz < NUM_SHIFTS; iz++) begin : g_z
                localparam int T = P * NUM_SHIFTS + iz;
                always_ff @(posedge i_clk) begin
                    r_s3[T]    <= SUM3_W'(r_sxy[P]) + SUM3_W'(r_z5.sq[iz]);
                    r_b3[T]    <= r_bxy[P] | r_z5.big[iz];
                    r_match[T] <= !r_b3[T] && (r_s3[T] < SUM3_W'(r_rc2));
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_z5 <= res_z;
        r_e5 <= r_excl_d[AXIS_LAT-1];
        r_e6 <= r_e5;
        r_e7 <= r_e6;
    end

    // highest matching image wins
    always_comb begin
        n_found = |r_match;
        n_code  = '0;
        for (int t = 0; t < NUM_IMAGES; t++) begin
            if (r_match[t]) begin
                n_code = CODE_W'(t);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_nb  <= n_found && !r_e7;
        r_fwd <= (n_found && !r_e7) ? n_code : '0;
        r_rev <= (n_found && !r_e7) ? (MAX_CODE - n_code) : '0;
    end

    assign o_done          = r_done;
    assign o_is_neighbor   = r_nb;
    assign o_image_forward = r_fwd;
    assign o_image_reverse = r_rev;

`ifndef NO_ASSERTIONS
    a_done_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, AXIS_LAT + 4))
        else $error("result strobe without an accepted item");
    a_codes_pair: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && o_is_neighbor |->
            (CODE_W + 1)'(o_image_forward) + (CODE_W + 1)'(o_image_reverse)
                == (CODE_W + 1)'(MAX_CODE))
        else $error("forward and reverse codes do not pair up");
    a_no_neighbor_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done && !o_is_neighbor |-> o_image_forward == '0 && o_image_reverse == '0)
        else $error("codes nonzero on a non-neighbor result");
    a_excl_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v7 && r_e7 |=> !o_is_neighbor)
        else $error("excluded pair reported as neighbor");
`endif

endmodule

`default_nettype wire
